### src/vbs_pkg.sv
// shared constants, config register codes and control structs for the
// vertical border search block; no dependencies
package vbs_pkg;

  localparam int IMG_WIDTH_DEF  = 512;
  localparam int IMG_HEIGHT_DEF = 512;

  // fixed field widths
  localparam int COORD_W   = 9;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int WHH_W     = 8;
  localparam int THR_W     = 8;
  localparam int INSET_W   = 4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_INSET          = 2'd2;

  // config reset values
  localparam logic [WHH_W-1:0]   WHH_RESET   = 8'd100;
  localparam logic [THR_W-1:0]   THR_RESET   = 8'd75;
  localparam logic [INSET_W-1:0] INSET_RESET = 4'd4;

  // request opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic load_write;
    logic rd_center;
    logic rd_win;
    logic win_clear;
    logic next_side;
    logic result_load;
    logic result_found;
  } vbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_edge;
    logic center_dark;
    logic idx_last;
    logic whh_zero;
    logic count_ge;
    logic side_right;
  } vbs_stat_t;

endpackage

### src/vbs_channels.sv
// request and result channel interfaces of the vertical border search
// depends on vbs_pkg
interface vbs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [vbs_pkg::COORD_W-1:0]  pixel_col;
  logic [vbs_pkg::COORD_W-1:0]  pixel_row;
  logic                         pixel_dark;
  logic [vbs_pkg::COORD_W-1:0]  left_x;
  logic [vbs_pkg::COORD_W-1:0]  left_y;
  logic [vbs_pkg::COORD_W-1:0]  right_x;
  logic [vbs_pkg::COORD_W-1:0]  right_y;

  modport source (
    output valid, opcode, pixel_col, pixel_row, pixel_dark,
           left_x, left_y, right_x, right_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, pixel_col, pixel_row, pixel_dark,
           left_x, left_y, right_x, right_y,
    output ready
  );
endinterface

interface vbs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vbs_pkg::COORD_W-1:0]  left_column;
  logic [vbs_pkg::COORD_W-1:0]  right_column;
  logic                         found;

  modport source (
    output valid, left_column, right_column, found,
    input  ready
  );
  modport sink (
    input  valid, left_column, right_column, found,
    output ready
  );
endinterface

### src/vertical_border_search_top.sv
// top level of the vertical border search: channels, config port and the
// controller / datapath pair; depends on vbs_pkg, vbs_channels, vbs_ctrl, vbs_datapath
//
// usage
//   req carries two kinds of request, chosen by opcode. a load request writes
//   pixel_dark into the dark map at (pixel_col, pixel_row); loads outside the
//   image are dropped. loads are taken one per cycle, back to back, and give
//   no result. a search request gives a box; the left edge starts at
//   left_x + box_inset and the right edge at right_x - box_inset, and each
//   side walks outward until a dark window stops it or it hits an image edge.
//   one result per search comes out on rsp: both columns and found.
//   steps of a search: a start, then per side step an edge check and a read
//   of the pixel left behind; when it is dark, a window scan (skipped when the
//   window is zero) and a decision on the dark row count; at the end the
//   result goes into the output register. the window scan reads one row pair
//   per cycle through the two read ports of the single map memory; the left
//   side runs to its end before the right side starts, one search at a time.
//   req.ready is high only while no search is running.
//   reset clears the control state and sets the config registers to their
//   defaults; the map holds whatever was loaded and must be loaded before use.
//   a stalled rsp holds its result; a finished search waits for it.
module vertical_border_search_top #(
  parameter int IMG_WIDTH  = vbs_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = vbs_pkg::IMG_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbs_pkg::CFG_W-1:0]      cfg_data,
  vbs_req_if.sink                        req,
  vbs_rsp_if.source                      rsp
);

  // command and status between the two halves
  vbs_pkg::vbs_cmd_t  cmd;
  vbs_pkg::vbs_stat_t stat;

  // sequencing: accepts requests and owns the result valid flag
  vbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // map memory, cursors, window count and the result payload register
  vbs_datapath #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_col    (req.pixel_col),
    .pixel_row    (req.pixel_row),
    .pixel_dark   (req.pixel_dark),
    .left_x       (req.left_x),
    .left_y       (req.left_y),
    .right_x      (req.right_x),
    .right_y      (req.right_y),
    .cmd          (cmd),
    .stat         (stat),
    .left_column  (rsp.left_column),
    .right_column (rsp.right_column),
    .found        (rsp.found)
  );

endmodule

### src/vbs_map_ram.sv
// one-bit dark map memory: one write port, two registered read ports
// no dependencies
module vbs_map_ram #(
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic                     rdata_a,
  output logic                     rdata_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/vbs_datapath.sv
// datapath: config registers, side cursors, window counter, map addressing
// depends on vbs_pkg and vbs_map_ram
module vbs_datapath #(
  parameter int IMG_WIDTH  = vbs_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = vbs_pkg::IMG_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vbs_pkg::CFG_W-1:0]       cfg_data,
  input  logic [vbs_pkg::COORD_W-1:0]     pixel_col,
  input  logic [vbs_pkg::COORD_W-1:0]     pixel_row,
  input  logic                            pixel_dark,
  input  logic [vbs_pkg::COORD_W-1:0]     left_x,
  input  logic [vbs_pkg::COORD_W-1:0]     left_y,
  input  logic [vbs_pkg::COORD_W-1:0]     right_x,
  input  logic [vbs_pkg::COORD_W-1:0]     right_y,
  input  vbs_pkg::vbs_cmd_t               cmd,
  output vbs_pkg::vbs_stat_t              stat,
  output logic [vbs_pkg::COORD_W-1:0]     left_column,
  output logic [vbs_pkg::COORD_W-1:0]     right_column,
  output logic                            found
);

  localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XBITS = $clog2(IMG_WIDTH);
  localparam int YBITS = $clog2(IMG_HEIGHT);
  localparam int CUR_W = ((XBITS > 10) ? XBITS : 10) + 1;
  localparam int ROW_W = ((YBITS > 10) ? YBITS : 10) + 1;
  localparam logic signed [CUR_W-1:0] CUR_ONE = 1;

  logic [vbs_pkg::WHH_W-1:0]   whh;
  logic [vbs_pkg::THR_W-1:0]   thr;
  logic [vbs_pkg::INSET_W-1:0] inset;

  logic signed [CUR_W-1:0]       cur_l, cur_r, cur_sel;
  logic [vbs_pkg::COORD_W-1:0]   row_l, row_r, row_sel;
  logic                          side;
  logic [vbs_pkg::WHH_W-1:0]     idx, off;
  logic [vbs_pkg::THR_W-1:0]     count;
  logic                          rd_win_valid;

  logic signed [ROW_W-1:0] ya, yb;
  logic                    x_in, inb_a, inb_b, inb_a_q, inb_b_q;
  logic                    rdata_a, rdata_b, hit_a, hit_b;
  logic                    load_in;
  logic [AW-1:0]           waddr, raddr_a, raddr_b;

  function automatic logic [AW-1:0] map_addr(logic [XBITS-1:0] x, logic [YBITS-1:0] y);
    return AW'(y * IMG_WIDTH) + AW'(x);
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      whh   <= vbs_pkg::WHH_RESET;
      thr   <= vbs_pkg::THR_RESET;
      inset <= vbs_pkg::INSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vbs_pkg::CFG_WINDOW_HALF_HEIGHT: whh   <= cfg_data[vbs_pkg::WHH_W-1:0];
        vbs_pkg::CFG_DARK_THRESHOLD:     thr   <= cfg_data[vbs_pkg::THR_W-1:0];
        vbs_pkg::CFG_BOX_INSET:          inset <= cfg_data[vbs_pkg::INSET_W-1:0];
        default: ;
      endcase
    end
  end

  // map addressing
  assign load_in = (int'(pixel_col) < IMG_WIDTH) && (int'(pixel_row) < IMG_HEIGHT);
  assign waddr   = map_addr(XBITS'(pixel_col), YBITS'(pixel_row));

  assign cur_sel = side ? cur_r : cur_l;
  assign row_sel = side ? row_r : row_l;
  assign off     = cmd.rd_win ? idx : '0;
  assign ya      = ROW_W'(row_sel) + ROW_W'(off);
  assign yb      = ROW_W'(row_sel) - ROW_W'(off);

  assign x_in  = (int'(cur_sel) >= 0) && (int'(cur_sel) < IMG_WIDTH);
  assign inb_a = x_in && (int'(ya) >= 0) && (int'(ya) < IMG_HEIGHT);
  assign inb_b = x_in && (int'(yb) >= 0) && (int'(yb) < IMG_HEIGHT);

  assign raddr_a = map_addr(XBITS'(cur_sel), YBITS'(ya));
  assign raddr_b = map_addr(XBITS'(cur_sel), YBITS'(yb));

  vbs_map_ram #(
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .we      (cmd.load_write && load_in),
    .waddr   (waddr),
    .wdata   (pixel_dark),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // outside the image reads as not dark
  assign hit_a = rdata_a && inb_a_q;
  assign hit_b = rdata_b && inb_b_q;

  always_ff @(posedge clk) begin
    inb_a_q <= inb_a;
    inb_b_q <= inb_b;
  end

  // cursors, window index and dark row count
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_l        <= '0;
      cur_r        <= '0;
      side         <= 1'b0;
      idx          <= '0;
      count        <= '0;
      rd_win_valid <= 1'b0;
    end else begin
      rd_win_valid <= cmd.rd_win;
      if (cmd.start) begin
        cur_l <= CUR_W'(left_x) + CUR_W'(inset);
        cur_r <= CUR_W'(right_x) - CUR_W'(inset);
        side  <= 1'b0;
      end else if (cmd.next_side) begin
        side <= 1'b1;
      end else if (cmd.rd_center) begin
        if (side) begin
          cur_r <= cur_r + CUR_ONE;
        end else begin
          cur_l <= cur_l - CUR_ONE;
        end
      end
      if (cmd.win_clear) begin
        idx   <= '0;
        count <= '0;
      end else begin
        if (cmd.rd_win) begin
          idx <= idx + 1'b1;
        end
        if (rd_win_valid && (hit_a || hit_b)) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_l <= left_y;
      row_r <= right_y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      found        <= cmd.result_found;
      left_column  <= cmd.result_found ? cur_l[vbs_pkg::COORD_W-1:0] : '0;
      right_column <= cmd.result_found ? cur_r[vbs_pkg::COORD_W-1:0] : '0;
    end
  end

  assign stat.at_edge     = side ? (int'(cur_r) >= IMG_WIDTH - 1) : (int'(cur_l) <= 0);
  assign stat.center_dark = hit_a;
  assign stat.idx_last    = ({1'b0, idx} + 9'd1) == {1'b0, whh};
  assign stat.whh_zero    = (whh == '0);
  assign stat.count_ge    = (count >= thr);
  assign stat.side_right  = side;

endmodule

### src/vbs_ctrl.sv
// controller: sequences loads, side steps, window scans and result hand-off
// depends on vbs_pkg
module vbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  vbs_pkg::vbs_stat_t  stat,
  output vbs_pkg::vbs_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_CENTER,
    S_WIN,
    S_TAIL,
    S_DECIDE,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   found, found_next;
  logic   out_valid_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    found_next     = found;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == vbs_pkg::OP_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = S_EDGE;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      S_EDGE: begin
        if (stat.at_edge) begin
          found_next = 1'b0;
          state_next = S_DONE;
        end else begin
          cmd.rd_center = 1'b1;
          state_next    = S_CENTER;
        end
      end
      S_CENTER: begin
        if (stat.center_dark) begin
          cmd.win_clear = 1'b1;
          state_next    = stat.whh_zero ? S_DECIDE : S_WIN;
        end else begin
          state_next = S_EDGE;
        end
      end
      S_WIN: begin
        cmd.rd_win = 1'b1;
        if (stat.idx_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.count_ge) begin
          if (stat.side_right) begin
            found_next = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.next_side = 1'b1;
            state_next    = S_EDGE;
          end
        end else begin
          state_next = S_EDGE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.result_load  = 1'b1;
          cmd.result_found = found;
          out_valid_next   = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      found     <= found_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_opcode == vbs_pkg::OP_SEARCH) |=> (state == S_EDGE))
    else $error("search request did not start a side step");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && in_opcode == vbs_pkg::OP_LOAD) |=> (state == S_IDLE))
    else $error("load request left the idle state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
